// ===== sv/rsc_pkg.sv =====
// Shared types and constants for the RPN stack calculator core.
// No dependencies; imported by the core and by its checker.
package rsc_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 64;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // Q16.16 words
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int QUO_W  = DATA_W + FRAC_W;

    // Iteration counter
    localparam int CNT_W = $clog2(QUO_W);

    typedef logic [2:0]        func_t;
    typedef logic [1:0]        status_t;
    typedef logic [DATA_W-1:0] word_t;

    // Function codes
    localparam func_t FN_PUSH = 3'd0;
    localparam func_t FN_ADD  = 3'd1;
    localparam func_t FN_SUB  = 3'd2;
    localparam func_t FN_MUL  = 3'd3;
    localparam func_t FN_DIV  = 3'd4;

    // Status codes
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_DIV0 = 2'd1;
    localparam status_t ST_FULL = 2'd2;
    localparam status_t ST_SAT  = 2'd3;

    // Saturation limits
    localparam word_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam word_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

// ===== sv/rpn_stack_calculator_core.sv =====
// RPN stack calculator core: operand stack, bit-serial add/sub, shift-add
// multiply, restoring divide. Depends on rsc_pkg.
//
// Usage:
//   Command channel: func and operand_value are taken at a rising edge where
//   start is high and busy is low. busy stays high until that word's result
//   has been produced; one word is worked on at a time.
//   Result channel: done pulses for one cycle with top_value, stack_depth and
//   status valid in that cycle. The receiver has no way to hold results off.
//   Push and unused codes go straight to write-back. The serial datapath
//   handles add / subtract one bit per cycle (32 bits), multiply one
//   multiplier bit per cycle and divide one quotient bit per cycle (48
//   bits); a zero divisor skips the divide loop.
//   A new word may be started in the cycle done is high.
//   The stack lives in a 64-entry RAM with a registered read port; the top
//   entry is also held in a register. Reset empties the stack (depth 0) and
//   clears all control state; RAM contents are not cleared.
module rpn_stack_calculator_core
    import rsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         func,
    input  logic signed [31:0] operand_value,
    output logic               done,
    output logic signed [31:0] top_value,
    output logic [6:0]         stack_depth,
    output logic [1:0]         status
);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_MRND = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_SAT  = 3'd6;
    localparam logic [2:0] S_WB   = 3'd7;

    localparam logic [CNT_W-1:0] ADD_LAST = CNT_W'(DATA_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

    logic [2:0]        state_reg, state_next;
    func_t             func_reg, func_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    word_t             top_reg, top_next;
    word_t             a_reg, a_next;
    word_t             b_reg, b_next;
    word_t             hi_reg, hi_next;
    logic [QUO_W-1:0]  lo_reg, lo_next;
    word_t             res_reg, res_next;
    logic              carry_reg, carry_next;
    logic              neg_reg, neg_next;
    status_t           st_reg, st_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    word_t             otop_reg, otop_next;
    logic [SP_W-1:0]   odepth_reg, odepth_next;
    status_t           ostat_reg, ostat_next;

    // Stack RAM
    word_t             stack_mem [STACK_DEPTH];
    word_t             rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [SP_W-1:0]   sp_m2;

    // Datapath terms
    word_t             op_a, op_b, a_mag, b_mag;
    logic              fa_s, fa_c;
    logic [DATA_W:0]   mul_sum, div_trial;
    logic              div_ok;
    logic [QUO_W-1:0]  mul_rnd;
    logic              mag_big;
    logic [SP_W-1:0]   sp_after;
    word_t             top_after;
    logic              is_op;

    assign sp_m2 = sp_reg - SP_W'(2);

    // Stack RAM: one write port, registered read of the entry below the top
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_wa] <= res_reg;
        end
        rd_data_reg <= stack_mem[sp_m2[ADDR_W-1:0]];
    end

    // Operands: empty slots read as zero
    assign op_a  = (sp_reg >= SP_W'(2)) ? rd_data_reg : '0;
    assign op_b  = (sp_reg != '0) ? top_reg : '0;
    assign a_mag = op_a[DATA_W-1] ? (~op_a + 1'b1) : op_a;
    assign b_mag = op_b[DATA_W-1] ? (~op_b + 1'b1) : op_b;

    // Bit-serial full adder
    assign fa_s = a_reg[0] ^ b_reg[0] ^ carry_reg;
    assign fa_c = (a_reg[0] & b_reg[0]) | (a_reg[0] & carry_reg) | (b_reg[0] & carry_reg);

    // Shift-add multiply step and restoring divide step
    assign mul_sum   = {1'b0, hi_reg} + {1'b0, (lo_reg[0] ? b_reg : '0)};
    assign div_trial = {hi_reg, lo_reg[QUO_W-1]} - {1'b0, b_reg};
    assign div_ok    = ~div_trial[DATA_W];

    // Product >> 16, rounded toward minus infinity for negative products
    assign mul_rnd = {hi_reg, lo_reg[DATA_W-1:FRAC_W]}
                   + QUO_W'(neg_reg && (lo_reg[FRAC_W-1:0] != '0));

    // Magnitude out of range for a signed word
    assign mag_big = neg_reg
        ? ((lo_reg[QUO_W-1:DATA_W] != '0) ||
           (lo_reg[DATA_W-1] && (lo_reg[DATA_W-2:0] != '0)))
        : (lo_reg[QUO_W-1:DATA_W-1] != '0);

    assign is_op = (func_reg == FN_ADD) || (func_reg == FN_SUB) ||
                   (func_reg == FN_MUL) || (func_reg == FN_DIV);

    // Stack update at write-back
    always_comb
    begin
        sp_after  = sp_reg;
        top_after = top_reg;
        mem_we    = 1'b0;
        mem_wa    = sp_reg[ADDR_W-1:0];
        if (state_reg == S_WB)
        begin
            if (func_reg == FN_PUSH)
            begin
                if (sp_reg != SP_W'(STACK_DEPTH))
                begin
                    mem_we    = 1'b1;
                    sp_after  = sp_reg + SP_W'(1);
                    top_after = res_reg;
                end
            end
            else if (is_op)
            begin
                // two pops then one push
                mem_we    = 1'b1;
                top_after = res_reg;
                if (sp_reg >= SP_W'(2))
                begin
                    mem_wa   = sp_m2[ADDR_W-1:0];
                    sp_after = sp_reg - SP_W'(1);
                end
                else
                begin
                    mem_wa   = '0;
                    sp_after = SP_W'(1);
                end
            end
        end
    end

    // Sequencer and serial datapath
    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        sp_next     = sp_reg;
        top_next    = top_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        res_next    = res_reg;
        carry_next  = carry_reg;
        neg_next    = neg_reg;
        st_next     = st_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        otop_next   = otop_reg;
        odepth_next = odepth_reg;
        ostat_next  = ostat_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next = func;
                    res_next  = operand_value;
                    st_next   = ST_OK;
                    if ((func == FN_ADD) || (func == FN_SUB) ||
                        (func == FN_MUL) || (func == FN_DIV))
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_WB;
                    end
                end
            end

            S_LOAD:
            begin
                cnt_next = '0;
                hi_next  = '0;
                neg_next = op_a[DATA_W-1] ^ op_b[DATA_W-1];
                unique case (func_reg)
                    FN_ADD, FN_SUB:
                    begin
                        a_next     = op_a;
                        b_next     = (func_reg == FN_SUB) ? ~op_b : op_b;
                        carry_next = (func_reg == FN_SUB);
                        neg_next   = op_a[DATA_W-1];
                        state_next = S_ADD;
                    end
                    FN_MUL:
                    begin
                        lo_next    = QUO_W'(a_mag);
                        b_next     = b_mag;
                        state_next = S_MUL;
                    end
                    FN_DIV:
                    begin
                        if (op_b == '0)
                        begin
                            res_next   = op_a[DATA_W-1] ? Q_MIN : Q_MAX;
                            st_next    = ST_DIV0;
                            state_next = S_WB;
                        end
                        else
                        begin
                            lo_next    = {a_mag, {FRAC_W{1'b0}}};
                            b_next     = b_mag;
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = S_WB;
                    end
                endcase
            end

            // one sum bit per cycle, LSB first
            S_ADD:
            begin
                a_next     = a_reg >> 1;
                b_next     = b_reg >> 1;
                res_next   = {fa_s, res_reg[DATA_W-1:1]};
                carry_next = fa_c;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == ADD_LAST)
                begin
                    // carry into sign differs from carry out: overflow
                    if (carry_reg ^ fa_c)
                    begin
                        res_next = neg_reg ? Q_MIN : Q_MAX;
                        st_next  = ST_SAT;
                    end
                    state_next = S_WB;
                end
            end

            // one multiplier bit per cycle
            S_MUL:
            begin
                hi_next              = mul_sum[DATA_W:1];
                lo_next[DATA_W-1:0]  = {mul_sum[0], lo_reg[DATA_W-1:1]};
                cnt_next             = cnt_reg + 1'b1;
                if (cnt_reg == ADD_LAST)
                begin
                    state_next = S_MRND;
                end
            end

            S_MRND:
            begin
                lo_next    = mul_rnd;
                state_next = S_SAT;
            end

            // one quotient bit per cycle, MSB first
            S_DIV:
            begin
                hi_next  = div_ok ? div_trial[DATA_W-1:0]
                                  : {hi_reg[DATA_W-2:0], lo_reg[QUO_W-1]};
                lo_next  = {lo_reg[QUO_W-2:0], div_ok};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_SAT;
                end
            end

            // apply sign and clamp the magnitude
            S_SAT:
            begin
                if (mag_big)
                begin
                    res_next = neg_reg ? Q_MIN : Q_MAX;
                    st_next  = ST_SAT;
                end
                else
                begin
                    res_next = neg_reg ? (~lo_reg[DATA_W-1:0] + 1'b1) : lo_reg[DATA_W-1:0];
                end
                state_next = S_WB;
            end

            S_WB:
            begin
                sp_next     = sp_after;
                top_next    = top_after;
                done_next   = 1'b1;
                odepth_next = sp_after;
                otop_next   = (sp_after != '0) ? top_after : '0;
                if ((func_reg == FN_PUSH) && (sp_reg == SP_W'(STACK_DEPTH)))
                begin
                    ostat_next = ST_FULL;
                end
                else
                begin
                    ostat_next = st_reg;
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            sp_reg     <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sp_reg     <= sp_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        top_reg    <= top_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        res_reg    <= res_next;
        carry_reg  <= carry_next;
        neg_reg    <= neg_next;
        st_reg     <= st_next;
        cnt_reg    <= cnt_next;
        otop_reg   <= otop_next;
        odepth_reg <= odepth_next;
        ostat_reg  <= ostat_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign top_value   = otop_reg;
    assign stack_depth = odepth_reg;
    assign status      = ostat_reg;

endmodule

// ===== sv/rsc_checker.sv =====
// Port-level checker for the RPN stack calculator core, bound to the top level.
// Depends on rsc_pkg and rpn_stack_calculator_core.
module rsc_checker
    import rsc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] top_value,
    input logic [6:0]         stack_depth,
    input logic [1:0]         status
);

    // An accepted word keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // A result comes out only once the word is finished
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && !$past(done)))
        else $error("result while busy or repeated");

    // An empty stack reads as zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (stack_depth == '0)) |-> (top_value == '0))
        else $error("nonzero top on empty stack");

    // A dropped push only happens on a full stack
    a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> (stack_depth == 7'(STACK_DEPTH)))
        else $error("push dropped below full depth");

    // Depth never exceeds the stack size
    a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (stack_depth <= 7'(STACK_DEPTH)))
        else $error("depth out of range");

endmodule

bind rpn_stack_calculator_core rsc_checker u_rsc_checker (.*);

// ===== tb/rpn_stack_calculator_core_tb.sv =====
// Self-checking testbench for rpn_stack_calculator_core: directed and random
// RPN word streams checked against an in-bench stack predictor.
// Depends on rsc_pkg and the core RTL.
`timescale 1ns / 1ps

module rpn_stack_calculator_core_tb;
    import rsc_pkg::*;

    localparam int RANDOM_WORDS = 1250;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        word_t   top;
        logic [6:0] depth;
        status_t st;
    } calc_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [2:0]         func = FN_PUSH;
    logic signed [31:0] operand_value = '0;
    logic               busy;
    logic               done;
    logic signed [31:0] top_value;
    logic [6:0]         stack_depth;
    logic [1:0]         status;

    // Predictor state: shadow operand stack and depth
    word_t        calc_stack [STACK_DEPTH];
    int           calc_depth = 0;
    calc_result_t pending_results [$];

    int mismatch_count = 0;
    int words_sent = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    rpn_stack_calculator_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .operand_value (operand_value),
        .done          (done),
        .top_value     (top_value),
        .stack_depth   (stack_depth),
        .status        (status)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Pop one shadow entry; an empty stack gives zero
    function automatic longint pop_operand();
        if (calc_depth == 0)
            return 0;
        calc_depth--;
        return longint'($signed(calc_stack[calc_depth]));
    endfunction

    // Apply one word to the shadow stack and queue the result it should give
    task automatic calc_step(input func_t f, input word_t v);
        longint       a;
        longint       b;
        longint       r64;
        word_t        r;
        status_t      st;
        calc_result_t res;
        st = ST_OK;
        if (f == FN_PUSH)
        begin
            if (calc_depth >= STACK_DEPTH)
                st = ST_FULL;
            else
            begin
                calc_stack[calc_depth] = v;
                calc_depth++;
            end
        end
        else if (f <= FN_DIV)
        begin
            b = pop_operand();
            a = pop_operand();
            r64 = 0;
            case (f)
                FN_ADD: r64 = a + b;
                FN_SUB: r64 = a - b;
                FN_MUL: r64 = (a * b) >>> 16;
                default:
                begin
                    if (b != 0)
                        r64 = (a * 65536) / b;
                end
            endcase
            if (f == FN_DIV && b == 0)
            begin
                r = (a >= 0) ? Q_MAX : Q_MIN;
                st = ST_DIV0;
            end
            else if (r64 > longint'($signed(Q_MAX)))
            begin
                r = Q_MAX;
                st = ST_SAT;
            end
            else if (r64 < longint'($signed(Q_MIN)))
            begin
                r = Q_MIN;
                st = ST_SAT;
            end
            else
                r = r64[31:0];
            calc_stack[calc_depth] = r;
            calc_depth++;
        end
        res.top   = (calc_depth > 0) ? calc_stack[calc_depth - 1] : '0;
        res.depth = calc_depth[6:0];
        res.st    = st;
        pending_results.push_back(res);
    endtask

    // Send one word, wait for it to be taken, then maybe idle for a gap
    task automatic send_word(input func_t f, input word_t v);
        int gap;
        start <= 1'b1;
        func <= f;
        operand_value <= v;
        do
            @(posedge clk);
        while (busy);
        calc_step(f, v);
        if (f <= FN_DIV)
            words_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
            // mostly short bursts, sometimes a long run with no idling
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 6);
        end
    endtask

    // Random Q16.16 word: extremes, zero, small fractions, integers or raw bits
    function automatic word_t rand_q();
        word_t w;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: w = Q_MAX;
                    1: w = Q_MIN;
                    2: w = 32'hFFFF_FFFF;
                    3: w = 32'h0000_0001;
                    default: w = 32'h0001_0000;
                endcase
            end
            1: w = '0;
            2, 3: w = $urandom_range(0, 32'h0008_0000);
            4: w = $urandom_range(0, 255) << FRAC_W;
            default: w = $urandom;
        endcase
        if ($urandom_range(0, 1) == 1 && w != Q_MIN)
            w = -w;
        return w;
    endfunction

    function automatic func_t rand_op();
        return func_t'(FN_ADD + $urandom_range(0, 3));
    endfunction

    // Operators on an empty stack pop zeros; 0 / 0 saturates positive
    task automatic test_empty_stack();
        send_word(FN_ADD, 32'h1234_5678);
        send_word(FN_DIV, '0);
    endtask

    // Exact results and saturation of each operator
    task automatic test_operators();
        send_word(FN_PUSH, 32'h0001_8000);
        send_word(FN_PUSH, 32'hFFFE_0000);
        send_word(FN_MUL, '0);
        send_word(FN_PUSH, 32'h0002_0000);
        send_word(FN_DIV, '0);
        send_word(FN_PUSH, 32'h0000_4000);
        send_word(FN_ADD, '0);
        send_word(FN_PUSH, 32'h0003_0000);
        send_word(FN_SUB, '0);
        send_word(FN_PUSH, Q_MAX);
        send_word(FN_PUSH, Q_MAX);
        send_word(FN_ADD, '0);
        send_word(FN_PUSH, Q_MAX);
        send_word(FN_MUL, '0);
        send_word(FN_PUSH, 32'hFFFF_FFFF);
        send_word(FN_DIV, '0);
        send_word(FN_PUSH, Q_MIN);
        send_word(FN_SUB, '0);
    endtask

    // Divide by zero with negative and positive dividends
    task automatic test_divide_by_zero();
        send_word(FN_PUSH, Q_MIN);
        send_word(FN_PUSH, '0);
        send_word(FN_DIV, '0);
        send_word(FN_PUSH, 32'h0001_0000);
        send_word(FN_PUSH, '0);
        send_word(FN_DIV, '0);
    endtask

    // Codes above divide leave the stack alone
    task automatic test_unused_codes();
        for (int c = FN_DIV + 1; c <= 7; c++)
            send_word(func_t'(c), $urandom);
    endtask

    // Random sequences: fill to full, drain past empty, or mixed traffic
    task automatic test_random_sequences(input int n_words);
        int    target;
        int    mode;
        int    len;
        int    r;
        target = words_sent + n_words;
        while (words_sent < target)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 2)
            begin
                while (calc_depth < STACK_DEPTH)
                    send_word(FN_PUSH, rand_q());
                len = $urandom_range(1, 3);
                repeat (len) send_word(FN_PUSH, rand_q());
            end
            else if (mode < 4)
            begin
                // an operator always leaves one entry, so drain down to one
                while (calc_depth > 1)
                    send_word(rand_op(), $urandom);
                len = $urandom_range(1, 2);
                repeat (len) send_word(rand_op(), $urandom);
            end
            else
            begin
                len = $urandom_range(5, 40);
                repeat (len)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 4)
                        send_word(func_t'(FN_DIV + $urandom_range(1, 3)), $urandom);
                    else if (r < 52)
                        send_word(FN_PUSH, rand_q());
                    else
                        send_word(rand_op(), $urandom);
                end
            end
        end
    endtask

    // Result checker: every done word against the oldest prediction
    always @(posedge clk)
    begin
        calc_result_t exp_word;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected word top=%h depth=%0d status=%0d",
                                          top_value, stack_depth, status));
            else
            begin
                exp_word = pending_results.pop_front();
                if (top_value !== exp_word.top)
                    report_mismatch($sformatf("top_value %h, predicted %h",
                                              top_value, exp_word.top));
                if (stack_depth !== exp_word.depth)
                    report_mismatch($sformatf("stack_depth %0d, predicted %0d",
                                              stack_depth, exp_word.depth));
                if (status !== exp_word.st)
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              status, exp_word.st));
            end
        end
    end

    // Watchdog: too long without a word taken or produced
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stack();
        test_operators();
        test_divide_by_zero();
        test_unused_codes();
        test_random_sequences(RANDOM_WORDS);

        if (start)
            start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
